// ===== sv/mexp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared word width, counter width and word and counter constants.
// ----------------------------------------------------------------------------
package mexp_pkg;

   localparam int WORD_WIDTH = 32;
   localparam int CNT_WIDTH  = $clog2(WORD_WIDTH);

   typedef logic [WORD_WIDTH-1:0] word_type;
   typedef logic [CNT_WIDTH-1:0]  cnt_type;

   localparam word_type WORD_ONE  = word_type'(1);
   localparam word_type WORD_ZERO = '0;
   localparam cnt_type  CNT_LAST  = cnt_type'(WORD_WIDTH - 1);

endpackage

// ===== sv/mexp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation channels
// Valid/ready request and response channels with their payload words.
// ----------------------------------------------------------------------------
interface mexp_req_if;
   logic               valid;
   logic               ready;
   mexp_pkg::word_type base;
   mexp_pkg::word_type exponent;
   mexp_pkg::word_type modulus;

   modport source (output valid, output base, output exponent, output modulus,
                   input ready);
   modport sink   (input valid, input base, input exponent, input modulus,
                   output ready);
endinterface

interface mexp_rsp_if;
   logic               valid;
   logic               ready;
   mexp_pkg::word_type result;
   logic               invalid;

   modport source (output valid, output result, output invalid, input ready);
   modport sink   (input valid, input result, input invalid, output ready);
endinterface

// ===== sv/mexp_mulmod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial modular multiplier
// Computes x * y mod m by shift-and-add, one multiplier bit per cycle, MSB
// first, with the reduction interleaved. Raises done after the last
// multiplier bit has been folded in.
// ----------------------------------------------------------------------------
module mexp_mulmod (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  mexp_pkg::word_type x,
   input  mexp_pkg::word_type y,
   input  mexp_pkg::word_type m,
   output logic               done,
   output mexp_pkg::word_type product
);

   localparam int W = mexp_pkg::WORD_WIDTH;

   mexp_pkg::word_type x_ff, x_in;
   mexp_pkg::word_type y_ff, y_in;
   mexp_pkg::word_type m_ff, m_in;
   mexp_pkg::word_type acc_ff, acc_in;
   mexp_pkg::cnt_type  cnt_ff, cnt_in;
   logic               run_ff, run_in;
   logic               done_ff, done_in;

   logic [W:0] dbl;
   logic [W:0] dbl_red;
   logic [W:0] sum;
   logic [W:0] sum_red;

   // acc < m, so 2*acc and (2*acc mod m) + x both stay below 2*m
   always_comb begin
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, m_ff}) ? dbl - {1'b0, m_ff} : dbl;
      sum     = dbl_red + {1'b0, x_ff};
      sum_red = (sum >= {1'b0, m_ff}) ? sum - {1'b0, m_ff} : sum;
   end

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      m_in    = m_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         x_in   = x;
         y_in   = y;
         m_in   = m;
         acc_in = mexp_pkg::WORD_ZERO;
         cnt_in = mexp_pkg::CNT_LAST;
         run_in = 1'b1;
      end else if (run_ff) begin
         acc_in = y_ff[W-1] ? sum_red[W-1:0] : dbl_red[W-1:0];
         y_in   = {y_ff[W-2:0], 1'b0};
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      m_ff   <= m_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ===== sv/modular_exponentiation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation
// Left-to-right square-and-multiply over a bit-serial modular multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one word of base, exponent and modulus; rsp returns one word
//   of result = base^exponent mod modulus and the invalid flag.
//   Hold req.valid until req.ready; one word is in flight at a time, and
//   req.ready is high only while the controller is idle.
//   A zero modulus answers result 0 with invalid set; a zero exponent
//   answers 1, even for a modulus of one. Both go straight to the emit state.
//   Otherwise the base is first reduced mod modulus, leading zero exponent
//   bits are skipped at one per cycle, and each remaining exponent bit costs
//   a square plus a multiply when the bit is set. Every modular product is
//   one pass of the shared serial multiplier, one multiplier bit per cycle.
//   The result sits in an output register: a stalled receiver holds it
//   there, and the block then takes the next request word while it waits,
//   pausing only if a second result is ready before the first is taken.
//   Synchronous reset drops any work in flight and clears rsp.valid.
// ----------------------------------------------------------------------------
module modular_exponentiation (
   input  logic          clock,
   input  logic          reset,
   mexp_req_if.sink      req,
   mexp_rsp_if.source    rsp
);

   localparam int W = mexp_pkg::WORD_WIDTH;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RED  = 3'd1;
   localparam logic [2:0] ST_SKIP = 3'd2;
   localparam logic [2:0] ST_SQR  = 3'd3;
   localparam logic [2:0] ST_MUL  = 3'd4;
   localparam logic [2:0] ST_EMIT = 3'd5;

   logic [2:0]         state_ff, state_in;
   mexp_pkg::word_type base_ff, base_in;
   mexp_pkg::word_type exp_ff, exp_in;
   mexp_pkg::word_type mod_ff, mod_in;
   mexp_pkg::cnt_type  cnt_ff, cnt_in;
   mexp_pkg::word_type res_ff, res_in;
   logic               inv_ff, inv_in;
   logic               rsp_valid_ff, rsp_valid_in;
   mexp_pkg::word_type rsp_result_ff, rsp_result_in;
   logic               rsp_invalid_ff, rsp_invalid_in;

   logic               mul_start;
   mexp_pkg::word_type mul_x, mul_y, mul_m;
   logic               mul_done;
   mexp_pkg::word_type mul_product;
   mexp_pkg::word_type z_init;
   logic               accept;

   mexp_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .x       (mul_x),
      .y       (mul_y),
      .m       (mul_m),
      .done    (mul_done),
      .product (mul_product)
   );

   assign accept = req.valid && req.ready;
   // 1 mod m: zero only for a modulus of one
   assign z_init = (mod_ff == mexp_pkg::WORD_ONE) ? mexp_pkg::WORD_ZERO
                                                  : mexp_pkg::WORD_ONE;
   // the multiplier latches the modulus on start
   assign mul_m  = (state_ff == ST_IDLE) ? req.modulus : mod_ff;

   always_comb begin
      state_in  = state_ff;
      base_in   = base_ff;
      exp_in    = exp_ff;
      mod_in    = mod_ff;
      cnt_in    = cnt_ff;
      res_in    = res_ff;
      inv_in    = inv_ff;
      mul_start = 1'b0;
      mul_x     = mul_product;
      mul_y     = mul_product;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               base_in = req.base;
               exp_in  = req.exponent;
               mod_in  = req.modulus;
               if (req.modulus == mexp_pkg::WORD_ZERO) begin
                  res_in   = mexp_pkg::WORD_ZERO;
                  inv_in   = 1'b1;
                  state_in = ST_EMIT;
               end else if (req.exponent == mexp_pkg::WORD_ZERO) begin
                  res_in   = mexp_pkg::WORD_ONE;
                  inv_in   = 1'b0;
                  state_in = ST_EMIT;
               end else begin
                  // reduce the base: 1 * base mod m
                  mul_start = 1'b1;
                  mul_x     = mexp_pkg::WORD_ONE;
                  mul_y     = req.base;
                  state_in  = ST_RED;
               end
            end
         end
         ST_RED: begin
            if (mul_done) begin
               base_in  = mul_product;
               cnt_in   = mexp_pkg::CNT_LAST;
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // drop leading zero exponent bits; bit 0 is always processed
            if (!exp_ff[W-1] && cnt_ff != '0) begin
               exp_in = {exp_ff[W-2:0], 1'b0};
               cnt_in = cnt_ff - 1'b1;
            end else begin
               mul_start = 1'b1;
               mul_x     = z_init;
               mul_y     = z_init;
               state_in  = ST_SQR;
            end
         end
         ST_SQR, ST_MUL: begin
            if (mul_done) begin
               if (state_ff == ST_SQR && exp_ff[W-1]) begin
                  mul_start = 1'b1;
                  mul_x     = mul_product;
                  mul_y     = base_ff;
                  state_in  = ST_MUL;
               end else if (cnt_ff == '0) begin
                  res_in   = mul_product;
                  inv_in   = 1'b0;
                  state_in = ST_EMIT;
               end else begin
                  // advance to the next exponent bit and square again
                  exp_in    = {exp_ff[W-2:0], 1'b0};
                  cnt_in    = cnt_ff - 1'b1;
                  mul_start = 1'b1;
                  state_in  = ST_SQR;
               end
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register: load a finished word once the slot is free
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_result_in  = rsp_result_ff;
      rsp_invalid_in = rsp_invalid_ff;
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == ST_EMIT && (!rsp_valid_ff || rsp.ready)) begin
         rsp_valid_in   = 1'b1;
         rsp_result_in  = res_ff;
         rsp_invalid_in = inv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      base_ff        <= base_in;
      exp_ff         <= exp_in;
      mod_ff         <= mod_in;
      cnt_ff         <= cnt_in;
      res_ff         <= res_in;
      inv_ff         <= inv_in;
      rsp_result_ff  <= rsp_result_in;
      rsp_invalid_ff <= rsp_invalid_in;
   end

   assign req.ready   = (state_ff == ST_IDLE);
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.result  = rsp_result_ff;
   assign rsp.invalid = rsp_invalid_ff;

endmodule
